// ===== rtl/core/c2p_pkg.sv =====
`timescale 1ns / 1ps

package c2p_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int ITERATIONS = 16;
    localparam int GUARD_BITS = 16;

    localparam int MAG_W = 16;
    localparam int ANG_W = 16;

    // Rotator coordinates: input width, guard bits, pre-rotation growth and CORDIC gain.
    localparam int CW = DATA_WIDTH + GUARD_BITS + 3;
    // Angle accumulator in units of pi/2^31, with headroom past +-pi.
    localparam int ZW = 33;
    localparam int ANG_SHIFT = 31 - (ANG_W - 1);

    localparam int SQ_W   = 2 * DATA_WIDTH;
    localparam int ROOT_W = DATA_WIDTH;
    localparam int REM_W  = DATA_WIDTH + 3;

    localparam int STAGES = (ITERATIONS > ROOT_W) ? ITERATIONS : ROOT_W;

    localparam logic signed [ZW-1:0] Z_HALF_PI = ZW'(64'sd1 <<< 30);

    localparam logic signed [ANG_W-1:0] ANGLE_ZERO     = '0;
    localparam logic signed [ANG_W-1:0] ANGLE_MAX      = {1'b0, {(ANG_W-1){1'b1}}};
    localparam logic signed [ANG_W-1:0] ANGLE_MIN      = {1'b1, {(ANG_W-1){1'b0}}};
    localparam logic signed [ANG_W-1:0] ANGLE_HALF_PI  = {2'b01, {(ANG_W-2){1'b0}}};
    localparam logic signed [ANG_W-1:0] ANGLE_NHALF_PI = {2'b11, {(ANG_W-2){1'b0}}};

    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    // atan(2^-i) in units of pi/2^31.
    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x_coord;
        logic signed [DATA_WIDTH-1:0] y_coord;
    } in_item_t;

    typedef struct packed {
        logic        [MAG_W-1:0] magnitude;
        logic signed [ANG_W-1:0] angle;
    } out_item_t;

    typedef struct packed {
        logic signed [CW-1:0]    cx;
        logic signed [CW-1:0]    cy;
        logic signed [ZW-1:0]    z;
        logic        [SQ_W-1:0]  radicand;
        logic        [ROOT_W-1:0] root;
        logic        [REM_W-1:0] rem;
        logic                    special;
        logic signed [ANG_W-1:0] spec_angle;
    } work_t;

    function automatic logic signed [ZW-1:0] atan_step(input int idx);
        logic [4:0] k;
        k = idx[4:0];
        if (idx < 32) begin
            return ZW'(ATAN_TABLE[k]);
        end
        return '0;
    endfunction

endpackage

// ===== rtl/core/c2p_prep.sv =====
`timescale 1ns / 1ps

module c2p_prep (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  c2p_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output c2p_pkg::work_t     out_data
);

    typedef struct packed {
        logic signed [c2p_pkg::CW-1:0]    cx;
        logic signed [c2p_pkg::CW-1:0]    cy;
        logic signed [c2p_pkg::ZW-1:0]    z;
        logic        [c2p_pkg::SQ_W-1:0]  sq_x;
        logic        [c2p_pkg::SQ_W-1:0]  sq_y;
        logic                             special;
        logic signed [c2p_pkg::ANG_W-1:0] spec_angle;
    } prep_t;

    localparam int EXT_W = c2p_pkg::CW - c2p_pkg::DATA_WIDTH;
    localparam int KEEP_W = c2p_pkg::CW - c2p_pkg::GUARD_BITS;

    logic  a_valid_reg;
    prep_t a_data_reg;
    prep_t a_data_next;
    logic  a_ready;

    logic           b_valid_reg;
    c2p_pkg::work_t b_data_reg;
    c2p_pkg::work_t b_data_next;
    logic           b_ready;

    logic signed [c2p_pkg::CW-1:0]   xe;
    logic signed [c2p_pkg::CW-1:0]   ye;
    logic signed [c2p_pkg::CW-1:0]   rx;
    logic signed [c2p_pkg::CW-1:0]   ry;
    logic signed [c2p_pkg::SQ_W-1:0] prod_x;
    logic signed [c2p_pkg::SQ_W-1:0] prod_y;
    logic                            x_zero;
    logic                            y_zero;

    assign xe = {{EXT_W{in_data.x_coord[c2p_pkg::DATA_WIDTH-1]}}, in_data.x_coord};
    assign ye = {{EXT_W{in_data.y_coord[c2p_pkg::DATA_WIDTH-1]}}, in_data.y_coord};
    assign prod_x = in_data.x_coord * in_data.x_coord;
    assign prod_y = in_data.y_coord * in_data.y_coord;
    assign x_zero = (in_data.x_coord == '0);
    assign y_zero = (in_data.y_coord == '0);

    // Left half plane points are turned by a quarter turn so the rotator starts with x >= 0.
    always_comb begin
        rx = xe;
        ry = ye;
        a_data_next.z = '0;
        if (in_data.x_coord[c2p_pkg::DATA_WIDTH-1]) begin
            if (!in_data.y_coord[c2p_pkg::DATA_WIDTH-1]) begin
                rx = ye;
                ry = -xe;
                a_data_next.z = c2p_pkg::Z_HALF_PI;
            end else begin
                rx = -ye;
                ry = xe;
                a_data_next.z = -c2p_pkg::Z_HALF_PI;
            end
        end
        a_data_next.cx = {rx[KEEP_W-1:0], {c2p_pkg::GUARD_BITS{1'b0}}};
        a_data_next.cy = {ry[KEEP_W-1:0], {c2p_pkg::GUARD_BITS{1'b0}}};
        a_data_next.sq_x = $unsigned(prod_x);
        a_data_next.sq_y = $unsigned(prod_y);
        a_data_next.special = x_zero || y_zero;
        if (x_zero && y_zero) begin
            a_data_next.spec_angle = c2p_pkg::ANGLE_ZERO;
        end else if (y_zero) begin
            a_data_next.spec_angle = in_data.x_coord[c2p_pkg::DATA_WIDTH-1] ?
                                     c2p_pkg::ANGLE_MAX : c2p_pkg::ANGLE_ZERO;
        end else begin
            a_data_next.spec_angle = in_data.y_coord[c2p_pkg::DATA_WIDTH-1] ?
                                     c2p_pkg::ANGLE_NHALF_PI : c2p_pkg::ANGLE_HALF_PI;
        end
    end

    always_comb begin
        b_data_next.cx         = a_data_reg.cx;
        b_data_next.cy         = a_data_reg.cy;
        b_data_next.z          = a_data_reg.z;
        b_data_next.radicand   = a_data_reg.sq_x + a_data_reg.sq_y;
        b_data_next.root       = '0;
        b_data_next.rem        = '0;
        b_data_next.special    = a_data_reg.special;
        b_data_next.spec_angle = a_data_reg.spec_angle;
    end

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_data_reg <= a_data_next;
        end
        if (b_ready && a_valid_reg) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

// ===== rtl/core/c2p_iter_pipe.sv =====
`timescale 1ns / 1ps

module c2p_iter_pipe (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  c2p_pkg::work_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output c2p_pkg::work_t out_data
);

    localparam int NST = c2p_pkg::STAGES;

    logic           valid_reg [NST];
    c2p_pkg::work_t data_reg  [NST];
    logic           stage_ready [NST];

    // Each stage does one CORDIC micro-rotation and one root digit of the square root.
    for (genvar g = 0; g < NST; g++) begin : g_stage
        c2p_pkg::work_t src;
        c2p_pkg::work_t data_next;
        logic           src_valid;
        logic           down_ready;

        logic signed [c2p_pkg::CW-1:0]     cx_n;
        logic signed [c2p_pkg::CW-1:0]     cy_n;
        logic signed [c2p_pkg::ZW-1:0]     z_n;
        logic        [c2p_pkg::ROOT_W-1:0] root_n;
        logic        [c2p_pkg::REM_W-1:0]  rem_n;

        if (g == 0) begin : g_src_in
            assign src       = in_data;
            assign src_valid = in_valid;
        end else begin : g_src_prev
            assign src       = data_reg[g-1];
            assign src_valid = valid_reg[g-1];
        end

        if (g == NST - 1) begin : g_down_out
            assign down_ready = out_ready;
        end else begin : g_down_next
            assign down_ready = stage_ready[g+1];
        end

        if (g < c2p_pkg::ITERATIONS) begin : g_rot
            logic signed [c2p_pkg::CW-1:0] dx;
            logic signed [c2p_pkg::CW-1:0] dy;
            logic signed [c2p_pkg::ZW-1:0] a;

            assign dx = src.cx >>> g;
            assign dy = src.cy >>> g;
            assign a  = c2p_pkg::atan_step(g);

            always_comb begin
                if (!src.cy[c2p_pkg::CW-1]) begin
                    cx_n = src.cx + dy;
                    cy_n = src.cy - dx;
                    z_n  = src.z + a;
                end else begin
                    cx_n = src.cx - dy;
                    cy_n = src.cy + dx;
                    z_n  = src.z - a;
                end
            end
        end else begin : g_rot_pass
            assign cx_n = src.cx;
            assign cy_n = src.cy;
            assign z_n  = src.z;
        end

        if (g < c2p_pkg::ROOT_W) begin : g_root
            localparam int J = c2p_pkg::ROOT_W - 1 - g;
            logic [c2p_pkg::REM_W-1:0] rem_sh;
            logic [c2p_pkg::REM_W-1:0] trial;

            assign rem_sh = {src.rem[c2p_pkg::REM_W-3:0], src.radicand[2*J+1 -: 2]};
            assign trial  = c2p_pkg::REM_W'({src.root, 2'b01});

            always_comb begin
                if (rem_sh >= trial) begin
                    rem_n  = rem_sh - trial;
                    root_n = {src.root[c2p_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_n  = rem_sh;
                    root_n = {src.root[c2p_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end else begin : g_root_pass
            assign rem_n  = src.rem;
            assign root_n = src.root;
        end

        always_comb begin
            data_next      = src;
            data_next.cx   = cx_n;
            data_next.cy   = cy_n;
            data_next.z    = z_n;
            data_next.root = root_n;
            data_next.rem  = rem_n;
        end

        assign stage_ready[g] = !valid_reg[g] || down_ready;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (stage_ready[g]) begin
                valid_reg[g] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[g] && src_valid) begin
                data_reg[g] <= data_next;
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NST-1];
    assign out_data  = data_reg[NST-1];

endmodule

// ===== rtl/core/c2p_finish.sv =====
`timescale 1ns / 1ps

module c2p_finish (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  c2p_pkg::work_t      in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output c2p_pkg::out_item_t  out_data
);

    localparam int RW = c2p_pkg::ROOT_W + 1;

    localparam logic signed [c2p_pkg::ZW-1:0] Z_ROUND = c2p_pkg::ZW'(64'sd1 <<< (c2p_pkg::ANG_SHIFT - 1));
    localparam logic signed [c2p_pkg::ZW-1:0] Z_AMAX  = c2p_pkg::ZW'(c2p_pkg::ANGLE_MAX);
    localparam logic signed [c2p_pkg::ZW-1:0] Z_AMIN  = c2p_pkg::ZW'(c2p_pkg::ANGLE_MIN);

    logic               out_valid_reg;
    c2p_pkg::out_item_t out_data_reg;
    c2p_pkg::out_item_t out_data_next;

    logic [RW-1:0]                 rounded;
    logic signed [c2p_pkg::ZW-1:0] z_round;
    logic signed [c2p_pkg::ZW-1:0] a_wide;

    // The remainder exceeds the root exactly when the true root is at least half a unit above it.
    assign rounded = RW'(in_data.root) +
                     RW'(in_data.rem > c2p_pkg::REM_W'(in_data.root));
    assign z_round = in_data.z + Z_ROUND;
    assign a_wide  = z_round >>> c2p_pkg::ANG_SHIFT;

    always_comb begin
        if (rounded > RW'(c2p_pkg::MAG_MAX)) begin
            out_data_next.magnitude = c2p_pkg::MAG_MAX;
        end else begin
            out_data_next.magnitude = rounded[c2p_pkg::MAG_W-1:0];
        end

        if (in_data.special) begin
            out_data_next.angle = in_data.spec_angle;
        end else if (a_wide > Z_AMAX) begin
            out_data_next.angle = c2p_pkg::ANGLE_MAX;
        end else if (a_wide < Z_AMIN) begin
            out_data_next.angle = c2p_pkg::ANGLE_MIN;
        end else begin
            out_data_next.angle = a_wide[c2p_pkg::ANG_W-1:0];
        end
    end

    assign in_ready = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/core/cartesian_to_polar_unit.sv =====
`timescale 1ns / 1ps

// Converts a signed Cartesian point to polar form: magnitude is sqrt(x*x + y*y) rounded to
// nearest, and angle is atan2(y, x) with 32768 standing for pi (pi itself saturates to 32767).
// The unit is a fully unrolled pipeline: the preparation registers form the squares and the quarter-turn
// pre-rotation, sixteen stages each perform one CORDIC micro-rotation alongside one digit of
// the square root, and a final stage rounds and registers the result. A transaction can be
// accepted every cycle while the output is not stalled. Every stage holds its own valid bit,
// so back-pressure only fills empty stages and input is still taken while a finished result
// waits at the output.
module cartesian_to_polar_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  c2p_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output c2p_pkg::out_item_t m_data
);

    logic           prep_valid;
    logic           prep_ready;
    c2p_pkg::work_t prep_data;

    logic           iter_valid;
    logic           iter_ready;
    c2p_pkg::work_t iter_data;

    c2p_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    c2p_iter_pipe u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (iter_valid),
        .out_ready (iter_ready),
        .out_data  (iter_data)
    );

    c2p_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (iter_valid),
        .in_ready  (iter_ready),
        .in_data   (iter_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// ===== dv/tb_cartesian_to_polar_unit.sv =====
`timescale 1ns / 1ps

module tb_cartesian_to_polar_unit;

    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 40;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_PER_SET = 670;
    localparam int REPORT_LIMIT   = 10;

    // Arctangent of 2^-i in units of pi/2^31.
    localparam logic [31:0] ARCTAN_STEPS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    c2p_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    c2p_pkg::out_item_t m_data;

    c2p_pkg::in_item_t  pending_points [$];
    c2p_pkg::out_item_t expected_polar [$];
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 mismatch_count = 0;
    int                 stall_cycles   = 0;

    cartesian_to_polar_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [15:0] rounded_root(longint n);
        longint r;
        longint trial;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = r | (longint'(1) << b);
            if (trial * trial <= n) begin
                r = trial;
            end
        end
        // Round to nearest: the root is at least r + 0.5 exactly when n - r*r exceeds r.
        if (n - r * r > r) begin
            r = r + 1;
        end
        if (r > 65535) begin
            r = 65535;
        end
        return 16'(r);
    endfunction

    function automatic longint vectoring_phase(longint px, longint py);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint step;
        x = px;
        y = py;
        z = 0;
        // Left half plane: turn by a quarter so the micro-rotations converge.
        if (x < 0) begin
            if (y >= 0) begin
                x = py;
                y = -px;
                z = longint'(1) << 30;
            end else begin
                x = -py;
                y = px;
                z = -(longint'(1) << 30);
            end
        end
        x = x <<< 16;
        y = y <<< 16;
        for (int i = 0; i < c2p_pkg::ITERATIONS; i++) begin
            dx = x >>> (i & 63);
            dy = y >>> (i & 63);
            step = (i < 32) ? longint'(ARCTAN_STEPS[i]) : 0;
            if (y >= 0) begin
                x = x + dy;
                y = y - dx;
                z = z + step;
            end else begin
                x = x - dy;
                y = y + dx;
                z = z - step;
            end
        end
        return z;
    endfunction

    function automatic c2p_pkg::out_item_t polar_of(c2p_pkg::in_item_t pt);
        c2p_pkg::out_item_t res;
        longint x;
        longint y;
        longint ang;
        x = pt.x_coord;
        y = pt.y_coord;
        res.magnitude = rounded_root(x * x + y * y);
        if (x == 0 && y == 0) begin
            ang = 0;
        end else if (y == 0) begin
            ang = (x > 0) ? 0 : 32767;
        end else if (x == 0) begin
            ang = (y > 0) ? 16384 : -16384;
        end else begin
            ang = (vectoring_phase(x, y) + 32768) >>> 16;
            if (ang > 32767) begin
                ang = 32767;
            end
            if (ang < -32768) begin
                ang = -32768;
            end
        end
        res.angle = 16'(ang);
        return res;
    endfunction

    task automatic queue_point(int x, int y);
        c2p_pkg::in_item_t p;
        p.x_coord = c2p_pkg::DATA_WIDTH'(x);
        p.y_coord = c2p_pkg::DATA_WIDTH'(y);
        pending_points.push_back(p);
    endtask

    function automatic int pick_extreme();
        int k;
        k = $urandom_range(5);
        case (k)
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            default: return 32767;
        endcase
    endfunction

    task automatic queue_random_points(int count);
        int kind;
        int x;
        int y;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(9);
            case (kind)
                5: begin
                    x = int'($urandom_range(16)) - 8;
                    y = int'($urandom_range(16)) - 8;
                end
                6: begin
                    // Close to the negative x axis, where the angle may run past pi.
                    x = -int'($urandom_range(32768, 1));
                    y = int'($urandom_range(6)) - 3;
                end
                7: begin
                    x = $signed(16'($urandom));
                    y = $signed(16'($urandom));
                    if ($urandom_range(1) == 0) begin
                        x = 0;
                    end else begin
                        y = 0;
                    end
                end
                8: begin
                    x = pick_extreme();
                    y = pick_extreme();
                end
                9: begin
                    x = $signed(16'($urandom));
                    y = ($urandom_range(1) == 0) ? x : -x;
                    y = y + int'($urandom_range(8)) - 4;
                    if (y > 32767) y = 32767;
                    if (y < -32768) y = -32768;
                end
                default: begin
                    x = $signed(16'($urandom));
                    y = $signed(16'($urandom));
                end
            endcase
            queue_point(x, y);
        end
    endtask

    task automatic wait_for_sent();
        while (pending_points.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Input driver: a new point is offered only when the channel is free.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_polar.push_back(polar_of(s_data));
            end
            if (pending_points.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_points.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        c2p_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_polar.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("Unexpected result: magnitude %0d angle %0d",
                                 m_data.magnitude, m_data.angle);
                    end
                end else begin
                    want = expected_polar.pop_front();
                    if (m_data.magnitude !== want.magnitude || m_data.angle !== want.angle) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("Result mismatch: expected magnitude %0d angle %0d, got %0d %0d",
                                     want.magnitude, want.angle,
                                     m_data.magnitude, m_data.angle);
                        end
                    end
                end
            end
            m_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        queue_point(0, 0);
        queue_point(32767, 0);
        queue_point(-32768, 0);
        queue_point(-1, 0);
        queue_point(1, 0);
        queue_point(0, 32767);
        queue_point(0, -32768);
        queue_point(0, 1);
        queue_point(0, -1);
        queue_point(1, 1);
        queue_point(-1, 1);
        queue_point(-1, -1);
        queue_point(1, -1);
        queue_point(32767, 32767);
        queue_point(-32768, -32768);
        queue_point(-32768, 32767);
        queue_point(32767, -32768);
        queue_point(-32768, 1);
        queue_point(-32768, -1);
        queue_point(-32767, 1);
        queue_point(-5, 3);
        queue_point(3, -5);
        queue_random_points(RANDOM_PER_SET);
        send_idle_pct  = 14;
        recv_stall_pct = 87;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        wait_for_sent();
        send_idle_pct  = 87;
        recv_stall_pct = 14;
        queue_random_points(RANDOM_PER_SET);
        wait_for_sent();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_points(RANDOM_PER_SET);
        wait_for_sent();

        while (s_valid || expected_polar.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
